// ===== rtl/sae_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the stack arithmetic executor.
// Depends on nothing; used by rtl/stack_arithmetic_executor_top.sv.
package sae_pkg;

	// Q16.16 data word and the fixed widths of the stream fields.
	localparam int DATA_W      = 32;
	localparam int FRAC_W      = 16;
	localparam int DEPTH_OUT_W = 9;
	localparam int CODE_W      = 3;

	// Default number of entries in the operand stack.
	localparam int STACK_DEPTH_DEF = 256;

	// The quotient is formed one bit per step from a 48-bit scaled dividend.
	localparam int DIV_STEPS = DATA_W + FRAC_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	// Saturation bounds of a signed 32-bit word.
	localparam logic [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	// Instruction codes carried in the input item.
	typedef enum logic [CODE_W-1:0] {
		OP_PUSH = 3'd0,
		OP_ADD  = 3'd1,
		OP_SUB  = 3'd2,
		OP_MUL  = 3'd3,
		OP_DIV  = 3'd4,
		OP_NEG  = 3'd5,
		OP_RET  = 3'd6
	} opcode_t;

	// Completion codes carried in the result item.
	typedef enum logic [CODE_W-1:0] {
		ST_OK  = 3'd0,
		ST_RET = 3'd1,
		ST_OVF = 3'd2,
		ST_UNF = 3'd3,
		ST_SAT = 3'd4
	} status_t;

endpackage

// ===== rtl/stack_arithmetic_executor_top.sv =====
`timescale 1ns / 1ps
// Stack machine executor: operand stack memory, one shared adder and a sequencer.
// Depends on rtl/sae_pkg.sv.
//
// Channel   Dir  Signals                                 Contents
// s_axis    in   tvalid tready tdata[31:0] tuser[2:0]    const_value, opcode
// m_axis    out  tvalid tready tdata[47:0] tuser[2:0]    result_value + stack_depth, status
//
// Push, overflow, underflow and the unused code pass from S_DECODE straight to S_FIN;
// add, subtract, negate, return and divide by zero also pass through S_OPER; multiply adds
// S_MULR (one registered 32x32 product); divide runs the 48 restoring steps through the
// shared adder in S_DIV, then S_DIVR. One item is in work at a time and s_axis_tready is high only while idle.
// A result left waiting on m_axis holds the sequencer in its final state. The stack
// contents are undefined after arst_n; only the stack pointer and control state are cleared.
module stack_arithmetic_executor_top #(
	parameter int STACK_DEPTH = sae_pkg::STACK_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [31:0] const_value
	input  logic [2:0]  s_axis_tuser,   // [2:0] opcode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,   // [31:0] result_value, [40:32] stack_depth, rest zero
	output logic [2:0]  m_axis_tuser    // [2:0] status
);

	localparam int DW   = sae_pkg::DATA_W;
	localparam int FW   = sae_pkg::FRAC_W;
	localparam int AW   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int SP_W = $clog2(STACK_DEPTH + 1);
	localparam int QW   = sae_pkg::DIV_STEPS;
	localparam int CW   = sae_pkg::DIV_CNT_W;
	localparam int ADD_W = DW + 2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_OPER,
		S_MULR,
		S_DIV,
		S_DIVR,
		S_FIN
	} state_t;

	state_t state_q;

	// Instruction registers and architectural state. The top of stack lives in tos_q;
	// the memory holds the entries below it.
	sae_pkg::opcode_t  op_q;
	logic [DW-1:0]     const_q;
	logic [SP_W-1:0]   sp_q;
	logic [DW-1:0]     tos_q;
	logic [DW-1:0]     ret_val_q;
	logic              ret_q;
	sae_pkg::status_t  status_q;

	// Multiply and divide working registers.
	logic signed [2*DW-1:0] prod_q;
	logic [QW-1:0]          dq_q;
	logic [DW-1:0]          rem_q;
	logic [DW-1:0]          bmag_q;
	logic                   qneg_q;
	logic [CW-1:0]          cnt_q;

	// Output register.
	logic                   m_valid_q;
	logic [DW-1:0]          m_value_q;
	logic [sae_pkg::DEPTH_OUT_W-1:0] m_depth_q;
	sae_pkg::status_t       m_status_q;

	// Operand stack memory.
	logic [DW-1:0] stack_mem [STACK_DEPTH];
	logic [DW-1:0] rdata_q;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;
	logic          mem_we;

	// Handshake.
	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {7'd0, m_depth_q, m_value_q};
	assign m_axis_tuser  = m_status_q;

	// Stack pointer decodes.
	logic sp_zero, sp_lt2, sp_full;
	logic [SP_W-1:0] sp_m1, sp_m2, sp_p1;
	assign sp_zero = (sp_q == '0);
	assign sp_lt2  = (sp_q < SP_W'(2));
	assign sp_full = (sp_q >= SP_W'(STACK_DEPTH));
	assign sp_m1   = sp_q - SP_W'(1);
	assign sp_m2   = sp_q - SP_W'(2);
	assign sp_p1   = sp_q + SP_W'(1);

	// The second entry is read continuously; a push spills the old top below the new one.
	assign rd_addr = sp_m2[AW-1:0];
	assign wr_addr = sp_m1[AW-1:0];
	assign mem_we  = (state_q == S_DECODE) && (op_q == sae_pkg::OP_PUSH) && !sp_full && !sp_zero;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			stack_mem[wr_addr] <= tos_q;
		end
		rdata_q <= stack_mem[rd_addr];
	end

	// Operands: a is the second entry (or the top for negate), b is the top.
	logic signed [DW-1:0] op_a, op_b;
	assign op_a = (op_q == sae_pkg::OP_NEG) ? tos_q : rdata_q;
	assign op_b = tos_q;

	// Shared adder: add, subtract and negate in S_OPER, trial subtract in S_DIV.
	logic [ADD_W-1:0] add_x, add_y, add_sum;
	logic             add_sub;
	logic [DW:0]      rem_next;
	assign rem_next = {rem_q, dq_q[QW-1]};

	always_comb begin
		add_x   = {{2{op_a[DW-1]}}, op_a};
		add_y   = {{2{op_b[DW-1]}}, op_b};
		add_sub = (op_q != sae_pkg::OP_ADD);
		if (state_q == S_DIV) begin
			add_x   = {1'b0, rem_next};
			add_y   = {2'b00, bmag_q};
			add_sub = 1'b1;
		end else if (op_q == sae_pkg::OP_NEG) begin
			add_x = '0;
			add_y = {{2{op_a[DW-1]}}, op_a};
		end
		add_sum = add_x + (add_sub ? ~add_y : add_y) + ADD_W'(add_sub);
	end

	// Saturation of the adder result to 32 bits.
	logic          add_ovf;
	logic [DW-1:0] add_clamped;
	assign add_ovf     = !((add_sum[ADD_W-1:DW-1] == '0) || (add_sum[ADD_W-1:DW-1] == '1));
	assign add_clamped = add_ovf ? (add_sum[ADD_W-1] ? sae_pkg::VAL_MIN : sae_pkg::VAL_MAX)
	                             : add_sum[DW-1:0];

	// Product scaled down by 2^16 with truncation toward zero, then saturated.
	logic signed [2*DW-1:0] prod_adj;
	logic [2*DW-FW-1:0]     prod_sh;
	logic                   mul_ovf;
	logic [DW-1:0]          mul_clamped;
	assign prod_adj    = prod_q + (prod_q[2*DW-1] ? (2*DW)'({FW{1'b1}}) : '0);
	assign prod_sh     = prod_adj[2*DW-1:FW];
	assign mul_ovf     = !((prod_sh[2*DW-FW-1:DW-1] == '0) || (prod_sh[2*DW-FW-1:DW-1] == '1));
	assign mul_clamped = mul_ovf ? (prod_sh[2*DW-FW-1] ? sae_pkg::VAL_MIN : sae_pkg::VAL_MAX)
	                             : prod_sh[DW-1:0];

	// Quotient sign and saturation.
	logic          div_ovf;
	logic [DW-1:0] div_clamped;
	always_comb begin
		if (qneg_q) begin
			div_ovf     = (dq_q > QW'({1'b1, {(DW-1){1'b0}}}));
			div_clamped = div_ovf ? sae_pkg::VAL_MIN : (~dq_q[DW-1:0] + DW'(1));
		end else begin
			div_ovf     = (dq_q > QW'(sae_pkg::VAL_MAX));
			div_clamped = div_ovf ? sae_pkg::VAL_MAX : dq_q[DW-1:0];
		end
	end

	// Operand magnitudes for the divider.
	logic [DW-1:0] amag, bmag;
	assign amag = op_a[DW-1] ? (~op_a + DW'(1)) : op_a;
	assign bmag = op_b[DW-1] ? (~op_b + DW'(1)) : op_b;

	// Sequencer, architectural state and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			sp_q       <= '0;
			ret_q      <= 1'b0;
			status_q   <= sae_pkg::ST_OK;
			m_valid_q  <= 1'b0;
			m_status_q <= sae_pkg::ST_OK;
			cnt_q      <= '0;
		end else begin
			// The final state loads the output register itself when it empties.
			if (m_valid_q && m_axis_tready && (state_q != S_FIN)) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						op_q    <= sae_pkg::opcode_t'(s_axis_tuser);
						const_q <= s_axis_tdata[DW-1:0];
						ret_q   <= 1'b0;
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					status_q <= sae_pkg::ST_OK;
					state_q  <= S_FIN;
					unique case (op_q)
						sae_pkg::OP_PUSH: begin
							if (sp_full) begin
								status_q <= sae_pkg::ST_OVF;
							end else begin
								tos_q <= const_q;
								sp_q  <= sp_p1;
							end
						end
						sae_pkg::OP_ADD, sae_pkg::OP_SUB,
						sae_pkg::OP_MUL, sae_pkg::OP_DIV: begin
							if (sp_lt2) begin
								status_q <= sae_pkg::ST_UNF;
							end else begin
								state_q <= S_OPER;
							end
						end
						sae_pkg::OP_NEG: begin
							if (sp_zero) begin
								status_q <= sae_pkg::ST_UNF;
							end else begin
								state_q <= S_OPER;
							end
						end
						sae_pkg::OP_RET: begin
							if (sp_zero) begin
								status_q <= sae_pkg::ST_UNF;
							end else begin
								status_q  <= sae_pkg::ST_RET;
								ret_q     <= 1'b1;
								ret_val_q <= tos_q;
								state_q   <= S_OPER;
							end
						end
						default: begin
							// Unused code: nothing changes.
						end
					endcase
				end
				S_OPER: begin
					state_q <= S_FIN;
					unique case (op_q)
						sae_pkg::OP_ADD, sae_pkg::OP_SUB: begin
							tos_q <= add_clamped;
							sp_q  <= sp_m1;
							if (add_ovf) status_q <= sae_pkg::ST_SAT;
						end
						sae_pkg::OP_NEG: begin
							tos_q <= add_clamped;
							if (add_ovf) status_q <= sae_pkg::ST_SAT;
						end
						sae_pkg::OP_MUL: begin
							prod_q  <= op_a * op_b;
							state_q <= S_MULR;
						end
						sae_pkg::OP_DIV: begin
							if (op_b == '0) begin
								// Division by zero gives the extreme of the dividend's sign.
								tos_q    <= op_a[DW-1] ? sae_pkg::VAL_MIN : sae_pkg::VAL_MAX;
								sp_q     <= sp_m1;
								status_q <= sae_pkg::ST_SAT;
							end else begin
								dq_q    <= {amag, {FW{1'b0}}};
								rem_q   <= '0;
								bmag_q  <= bmag;
								qneg_q  <= op_a[DW-1] ^ op_b[DW-1];
								cnt_q   <= '0;
								state_q <= S_DIV;
							end
						end
						default: begin
							// Return: the entry below becomes the new top.
							tos_q <= rdata_q;
							sp_q  <= sp_m1;
						end
					endcase
				end
				S_MULR: begin
					tos_q   <= mul_clamped;
					sp_q    <= sp_m1;
					if (mul_ovf) status_q <= sae_pkg::ST_SAT;
					state_q <= S_FIN;
				end
				S_DIV: begin
					// One restoring step: keep the difference when it did not borrow.
					if (!add_sum[ADD_W-1]) begin
						rem_q <= add_sum[DW-1:0];
						dq_q  <= {dq_q[QW-2:0], 1'b1};
					end else begin
						rem_q <= rem_next[DW-1:0];
						dq_q  <= {dq_q[QW-2:0], 1'b0};
					end
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(QW - 1)) begin
						state_q <= S_DIVR;
					end
				end
				S_DIVR: begin
					tos_q   <= div_clamped;
					sp_q    <= sp_m1;
					if (div_ovf) status_q <= sae_pkg::ST_SAT;
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (!m_valid_q || m_axis_tready) begin
						m_valid_q  <= 1'b1;
						m_status_q <= status_q;
						m_depth_q  <= sae_pkg::DEPTH_OUT_W'(sp_q);
						if (ret_q) begin
							m_value_q <= ret_val_q;
						end else begin
							m_value_q <= sp_zero ? '0 : tos_q;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
